@@ rtl/core/two_stacks_shared_buffer_macros.svh @@
// assertion macros for the two stacks shared buffer
// used by tssb_ctrl and tssb_datapath; expects clk and rst_n in scope
`ifndef TWO_STACKS_SHARED_BUFFER_MACROS_SVH
`define TWO_STACKS_SHARED_BUFFER_MACROS_SVH

// checked property, masked while reset is held
`define TSSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property, also during reset
`define TSSB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/tssb_pkg.sv @@
// shared types and constants for the two stacks shared buffer
// no dependencies
package tssb_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 3;
    localparam int ITEM_W     = 32;
    localparam int RDATA_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_TDATA_W = ((OPCODE_W + ITEM_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_PUSH_ONE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_TWO = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_ONE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_TWO  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK_ONE = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK_TWO = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;
        logic exec;
    } tssb_cmd_t;

    typedef struct packed {
        logic out_free;
    } tssb_sts_t;

endpackage

@@ rtl/core/tssb_ctrl.sv @@
// sequencer for the two stacks shared buffer: accept, then execute
// depends on tssb_pkg and two_stacks_shared_buffer_macros.svh
`include "two_stacks_shared_buffer_macros.svh"

module tssb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output tssb_pkg::tssb_cmd_t cmd,
    input  tssb_pkg::tssb_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready   = (state_reg == ST_IDLE) && sts.out_free;
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.exec   = (state_reg == ST_EXEC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TSSB_ASSERT(a_accept_to_exec, cmd.accept |=> cmd.exec, "accept not followed by execute")
    `TSSB_ASSERT(a_exec_one_cycle, cmd.exec |=> (state_reg == ST_IDLE), "execute longer than a cycle")
    `TSSB_ASSERT_ALWAYS(a_no_ready_busy, cmd.exec |-> !s_tready, "ready while executing")

endmodule

@@ rtl/core/tssb_datapath.sv @@
// stack counters, shared word memory and result register
// depends on tssb_pkg and two_stacks_shared_buffer_macros.svh
`include "two_stacks_shared_buffer_macros.svh"

module tssb_datapath
#(
    parameter int DEPTH      = tssb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tssb_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tssb_pkg::tssb_cmd_t           cmd,
    output tssb_pkg::tssb_sts_t           sts,
    input  logic [tssb_pkg::OPCODE_W-1:0] opcode,
    input  logic [tssb_pkg::ITEM_W-1:0]   item_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tssb_pkg::RDATA_W-1:0]  read_data,
    output logic [tssb_pkg::STATUS_W-1:0] status,
    output logic [CW-1:0]                 depth_one,
    output logic [CW-1:0]                 depth_two
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam int ITEM_PAD = tssb_pkg::ITEM_W;
    localparam int RD_PAD   = tssb_pkg::RDATA_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [tssb_pkg::OPCODE_W-1:0] op_reg;
    logic [DATA_WIDTH-1:0]         data_reg;
    logic [DATA_WIDTH-1:0]         rdata_reg;
    logic [CW-1:0]                 count_one_reg;
    logic [CW-1:0]                 count_one_next;
    logic [CW-1:0]                 count_two_reg;
    logic [CW-1:0]                 count_two_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tssb_pkg::RDATA_W-1:0]  out_rdata_reg;
    logic [tssb_pkg::RDATA_W-1:0]  out_rdata_next;
    logic [tssb_pkg::STATUS_W-1:0] out_status_reg;
    logic [tssb_pkg::STATUS_W-1:0] out_status_next;

    logic [CW:0]                         fill_sum;
    logic                                full;
    logic                                we;
    logic [CW-1:0]                       waddr_full;
    logic [CW-1:0]                       raddr_full;
    logic [DATA_WIDTH+ITEM_PAD-1:0]      wr_ext;
    logic [DATA_WIDTH+RD_PAD-1:0]        rd_ext;

    assign fill_sum = {1'b0, count_one_reg} + {1'b0, count_two_reg};
    assign full     = (fill_sum >= {1'b0, DEPTH_C});
    assign wr_ext   = {{DATA_WIDTH{1'b0}}, item_data};
    assign rd_ext   = {{RD_PAD{1'b0}}, rdata_reg};

    // read address from the incoming opcode, data is ready in the execute cycle
    always_comb
    begin
        if (opcode == tssb_pkg::OP_POP_ONE || opcode == tssb_pkg::OP_PEEK_ONE)
        begin
            raddr_full = count_one_reg - ONE_C;
        end
        else
        begin
            raddr_full = DEPTH_C - count_two_reg;
        end
    end

    always_comb
    begin
        we              = 1'b0;
        waddr_full      = count_one_reg;
        count_one_next  = count_one_reg;
        count_two_next  = count_two_reg;
        out_rdata_next  = '0;
        out_status_next = tssb_pkg::STATUS_OK;
        case (op_reg)
            tssb_pkg::OP_PUSH_ONE:
            begin
                if (full)
                begin
                    out_status_next = tssb_pkg::STATUS_FULL;
                end
                else
                begin
                    we             = 1'b1;
                    count_one_next = count_one_reg + ONE_C;
                end
            end
            tssb_pkg::OP_PUSH_TWO:
            begin
                waddr_full = DEPTH_C - ONE_C - count_two_reg;
                if (full)
                begin
                    out_status_next = tssb_pkg::STATUS_FULL;
                end
                else
                begin
                    we             = 1'b1;
                    count_two_next = count_two_reg + ONE_C;
                end
            end
            tssb_pkg::OP_POP_ONE, tssb_pkg::OP_PEEK_ONE:
            begin
                if (count_one_reg == '0)
                begin
                    out_status_next = tssb_pkg::STATUS_EMPTY;
                end
                else
                begin
                    out_rdata_next = rd_ext[tssb_pkg::RDATA_W-1:0];
                    if (op_reg == tssb_pkg::OP_POP_ONE)
                    begin
                        count_one_next = count_one_reg - ONE_C;
                    end
                end
            end
            tssb_pkg::OP_POP_TWO, tssb_pkg::OP_PEEK_TWO:
            begin
                if (count_two_reg == '0)
                begin
                    out_status_next = tssb_pkg::STATUS_EMPTY;
                end
                else
                begin
                    out_rdata_next = rd_ext[tssb_pkg::RDATA_W-1:0];
                    if (op_reg == tssb_pkg::OP_POP_TWO)
                    begin
                        count_two_next = count_two_reg - ONE_C;
                    end
                end
            end
            default:
            begin
                out_status_next = tssb_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
    end

    // shared word memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
        begin
            mem[waddr_full[AW-1:0]] <= data_reg;
        end
        if (cmd.accept)
        begin
            rdata_reg <= mem[raddr_full[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            data_reg <= wr_ext[DATA_WIDTH-1:0];
        end
        if (cmd.exec)
        begin
            out_rdata_reg  <= out_rdata_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_one_reg <= '0;
            count_two_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_one_reg <= count_one_next;
                count_two_reg <= count_two_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign read_data    = out_rdata_reg;
    assign status       = out_status_reg;
    assign depth_one    = count_one_reg;
    assign depth_two    = count_two_reg;

    `TSSB_ASSERT_ALWAYS(a_fill_bound, fill_sum <= {1'b0, DEPTH_C}, "stacks overlap")
    `TSSB_ASSERT(a_exec_out_free, cmd.exec |-> !out_valid_reg, "result register overwritten")
    `TSSB_ASSERT(a_pop_one_dec,
        (cmd.exec && op_reg == tssb_pkg::OP_POP_ONE && count_one_reg != '0)
        |=> (count_one_reg == $past(count_one_reg) - ONE_C),
        "pop did not shrink stack one")

endmodule

@@ rtl/core/two_stacks_shared_buffer.sv @@
// top level of the two stacks shared buffer
// depends on tssb_pkg, tssb_ctrl and tssb_datapath
//
// channel   dir  fields (lowest bit first)
// s_*       in   opcode[2:0], item_data[34:3], zero pad to 40 bits
// m_*       out  read_data[31:0], status[33:32], depth_one[44:34], depth_two[55:45]
//
// each word is accepted with a memory read, then executed with the result loaded
// the result register frees at the same edge it is taken, so a word may follow at once
// s_tready stays low during execute, so no new word is taken until the last has executed
// m_tready low holds the result and blocks s_tready until it is taken
// reset empties both stacks; memory contents are undefined until pushed
module two_stacks_shared_buffer
#(
    parameter int DEPTH      = tssb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tssb_pkg::DATA_WIDTH_DEF,
    parameter int CW         = $clog2(DEPTH + 1),
    parameter int OUT_W      = ((tssb_pkg::RDATA_W + tssb_pkg::STATUS_W + 2 * CW + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tssb_pkg::IN_TDATA_W-1:0] s_tdata,  // opcode, item_data
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata   // read_data, status, depth_one, depth_two
);

    tssb_pkg::tssb_cmd_t cmd;
    tssb_pkg::tssb_sts_t sts;

    logic [tssb_pkg::RDATA_W-1:0]  read_data;
    logic [tssb_pkg::STATUS_W-1:0] status;
    logic [CW-1:0]                 depth_one;
    logic [CW-1:0]                 depth_two;

    tssb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tssb_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         ($clog2(DEPTH)),
        .CW         (CW)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (s_tdata[tssb_pkg::OPCODE_W-1:0]),
        .item_data (s_tdata[tssb_pkg::OPCODE_W +: tssb_pkg::ITEM_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .read_data (read_data),
        .status    (status),
        .depth_one (depth_one),
        .depth_two (depth_two)
    );

    assign m_tdata = OUT_W'({depth_two, depth_one, status, read_data});

endmodule
